/* src/frustum_cull_tester_defines.svh */
// Assertion macros shared by the frustum cull tester RTL.
`ifndef FRUSTUM_CULL_TESTER_DEFINES_SVH
`define FRUSTUM_CULL_TESTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define FCT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define FCT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/fct_pkg.sv */
// Shared constants, codes and types of the frustum cull tester.
package fct_pkg;

    localparam int NUM_PLANES_DEF  = 6;
    localparam int COORD_BITS_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COEF_BITS       = 32;
    localparam int NUM_COEFS       = 4;
    localparam int NUM_CORNERS     = 8;

    // Item kinds
    localparam logic [1:0] KIND_WRITE  = 2'd0;
    localparam logic [1:0] KIND_SPHERE = 2'd1;
    localparam logic [1:0] KIND_BOX    = 2'd2;

    // Coefficient indexes within a plane
    localparam logic [1:0] COEF_A = 2'd0;
    localparam logic [1:0] COEF_B = 2'd1;
    localparam logic [1:0] COEF_C = 2'd2;
    localparam logic [1:0] COEF_D = 2'd3;

    // One step issued to the dot product unit
    typedef struct packed {
        logic valid;
        logic first;      // coefficient a: restart the sum
        logic last;       // coefficient d: sum complete after this term
        logic use_const;  // add (d + radius) << frac instead of a product
        logic plane_end;  // last corner of the current plane
        logic query_end;  // last corner of the last plane
    } dot_op_t;

    // One finished plane distance
    typedef struct packed {
        logic valid;
        logic neg;
        logic plane_end;
        logic query_end;
    } dot_res_t;

endpackage

/* src/frustum_cull_tester.sv */
// Top level of the frustum cull tester: sequencer, plane store and dot product unit.
//
// Frustum cull tester for spheres and axis-aligned boxes. A write beat
// (kind 0) stores one Q16.16 coefficient of one plane and returns nothing;
// writes to planes at or beyond NUM_PLANES and beats of kind 3 are dropped.
// A sphere or box query returns one beat with visible and fully_inside.
// Each plane distance is summed exactly by one shared multiply-accumulate
// unit, one coefficient term per cycle; a box query tests all eight corners
// against every plane. in_ready is low while a query runs; a finished result
// sits in the output register, and the block takes new beats while it waits
// there. Distances of exactly zero pass a plane.
`include "frustum_cull_tester_defines.svh"
module frustum_cull_tester import fct_pkg::*; #(
    parameter int NUM_PLANES = NUM_PLANES_DEF,
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [1:0]                   kind,
    input  logic [2:0]                   plane_index,
    input  logic [1:0]                   coef_index,
    input  logic signed [COEF_BITS-1:0]  coef_value,
    input  logic signed [COORD_BITS-1:0] point_x,
    input  logic signed [COORD_BITS-1:0] point_y,
    input  logic signed [COORD_BITS-1:0] point_z,
    input  logic [COORD_BITS-2:0]        radius,
    input  logic signed [COORD_BITS-1:0] max_x,
    input  logic signed [COORD_BITS-1:0] max_y,
    input  logic signed [COORD_BITS-1:0] max_z,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic                         visible,
    output logic                         fully_inside
);

    localparam int PIDX_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic                         is_box_reg;
    logic signed [COORD_BITS-1:0] lo_x_reg, lo_y_reg, lo_z_reg;
    logic signed [COORD_BITS-1:0] hi_x_reg, hi_y_reg, hi_z_reg;
    logic [COORD_BITS-2:0]        radius_reg;
    logic [1:0]                   coef_cnt_reg;
    logic [2:0]                   corner_cnt_reg;
    logic [PIDX_W-1:0]            plane_cnt_reg;
    logic [3:0]                   behind_cnt_reg;
    logic                         vis_reg;
    logic                         inside_reg;
    logic                         out_valid_reg;
    logic                         out_visible_reg;
    logic                         out_inside_reg;

    logic                         accept;
    logic                         wr_en;
    logic                         start;
    logic                         coef_last;
    logic                         corner_last;
    logic                         plane_last;
    logic                         out_free;
    logic [3:0]                   n_corners;
    logic [3:0]                   behind_total;
    logic [COEF_BITS-1:0]         rd_data;
    logic signed [COORD_BITS-1:0] coord_sel;
    dot_op_t                      issue_op;
    dot_res_t                     dot_res;

    // Input handshake
    assign in_ready = (state_reg == ST_IDLE);
    assign accept   = in_valid && in_ready;
    assign wr_en    = accept && (kind == KIND_WRITE);
    assign start    = accept && ((kind == KIND_SPHERE) || (kind == KIND_BOX));

    // Loop bounds of the sequencer
    assign coef_last   = (coef_cnt_reg == COEF_D);
    assign corner_last = is_box_reg ? (corner_cnt_reg == 3'(NUM_CORNERS - 1))
                                    : (corner_cnt_reg == 3'd0);
    assign plane_last  = (plane_cnt_reg == PIDX_W'(NUM_PLANES - 1));
    assign n_corners   = is_box_reg ? 4'(NUM_CORNERS) : 4'd1;
    assign out_free    = !out_valid_reg || out_ready;

    // Pick the corner coordinate that goes with this coefficient
    always_comb
    begin
        unique case (coef_cnt_reg)
            COEF_A:  coord_sel = corner_cnt_reg[0] ? hi_x_reg : lo_x_reg;
            COEF_B:  coord_sel = corner_cnt_reg[1] ? hi_y_reg : lo_y_reg;
            COEF_C:  coord_sel = corner_cnt_reg[2] ? hi_z_reg : lo_z_reg;
            default: coord_sel = lo_x_reg;
        endcase
    end

    // Issue one term per cycle while running
    always_comb
    begin
        issue_op.valid     = (state_reg == ST_RUN);
        issue_op.first     = (coef_cnt_reg == COEF_A);
        issue_op.last      = coef_last;
        issue_op.use_const = coef_last;
        issue_op.plane_end = corner_last;
        issue_op.query_end = corner_last && plane_last;
    end

    fct_plane_store #(
        .NUM_PLANES (NUM_PLANES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_plane (plane_index),
        .wr_coef  (coef_index),
        .wr_data  (coef_value),
        .rd_plane (plane_cnt_reg),
        .rd_coef  (coef_cnt_reg),
        .rd_data  (rd_data)
    );

    fct_dot_unit #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_dot (
        .clk    (clk),
        .rst_n  (rst_n),
        .op     (issue_op),
        .coef   ($signed(rd_data)),
        .coord  (coord_sel),
        .radius (radius_reg),
        .res    (dot_res)
    );

    assign behind_total = behind_cnt_reg + {3'b000, dot_res.neg};

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (coef_last && corner_last && plane_last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (dot_res.valid && dot_res.query_end)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Control state: sequencer, counters, verdict and output beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            is_box_reg     <= 1'b0;
            coef_cnt_reg   <= COEF_A;
            corner_cnt_reg <= 3'd0;
            plane_cnt_reg  <= '0;
            behind_cnt_reg <= 4'd0;
            vis_reg        <= 1'b1;
            inside_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // Open a query
            if (start)
            begin
                is_box_reg     <= (kind == KIND_BOX);
                vis_reg        <= 1'b1;
                inside_reg     <= (kind == KIND_BOX);
                behind_cnt_reg <= 4'd0;
            end

            // Advance coefficient, corner and plane
            if (state_reg == ST_RUN)
            begin
                coef_cnt_reg <= coef_cnt_reg + 2'd1;
                if (coef_last)
                begin
                    if (corner_last)
                    begin
                        corner_cnt_reg <= 3'd0;
                        plane_cnt_reg  <= plane_last ? '0 : plane_cnt_reg + PIDX_W'(1);
                    end
                    else
                    begin
                        corner_cnt_reg <= corner_cnt_reg + 3'd1;
                    end
                end
            end

            // Fold each finished distance into the verdict
            if (dot_res.valid)
            begin
                if (dot_res.neg)
                begin
                    inside_reg <= 1'b0;
                end
                if (dot_res.plane_end)
                begin
                    behind_cnt_reg <= 4'd0;
                    if (behind_total == n_corners)
                    begin
                        vis_reg    <= 1'b0;
                        inside_reg <= 1'b0;
                    end
                end
                else
                begin
                    behind_cnt_reg <= behind_total;
                end
            end

            // Output beat
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Query operands and output payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            lo_x_reg   <= point_x;
            lo_y_reg   <= point_y;
            lo_z_reg   <= point_z;
            hi_x_reg   <= max_x;
            hi_y_reg   <= max_y;
            hi_z_reg   <= max_z;
            radius_reg <= (kind == KIND_BOX) ? '0 : radius;
        end
        if ((state_reg == ST_DONE) && out_free)
        begin
            out_visible_reg <= vis_reg;
            out_inside_reg  <= inside_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign visible      = out_visible_reg;
    assign fully_inside = out_inside_reg;

    // Checks
    `FCT_ASSERT_IMP(a_res_while_busy, dot_res.valid, (state_reg == ST_RUN) || (state_reg == ST_DRAIN), "distance result outside a query")
    `FCT_ASSERT_NEXT(a_end_to_done, dot_res.valid && dot_res.query_end, state_reg == ST_DONE, "last distance did not close the query")
    `FCT_ASSERT_IMP(a_cnt_parked, state_reg != ST_RUN, (coef_cnt_reg == COEF_A) && (corner_cnt_reg == 3'd0), "sequencer counters not parked")
    `FCT_ASSERT_IMP(a_behind_bound, 1'b1, behind_cnt_reg < n_corners, "behind count reached corner count")

endmodule

/* src/fct_plane_store.sv */
// Plane coefficient register file, cleared at reset, one write and one read port.
module fct_plane_store import fct_pkg::*; #(
    parameter int NUM_PLANES = NUM_PLANES_DEF,
    localparam int PIDX_W    = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [2:0]           wr_plane,
    input  logic [1:0]           wr_coef,
    input  logic [COEF_BITS-1:0] wr_data,
    input  logic [PIDX_W-1:0]    rd_plane,
    input  logic [1:0]           rd_coef,
    output logic [COEF_BITS-1:0] rd_data
);

    logic [COEF_BITS-1:0] store_reg [NUM_PLANES][NUM_COEFS];
    logic                 wr_hit;

    // Drop writes to planes beyond the store
    assign wr_hit = wr_en && ({1'b0, wr_plane} < 4'(NUM_PLANES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                for (int k = 0; k < NUM_COEFS; k++)
                begin
                    store_reg[p][k] <= '0;
                end
            end
        end
        else if (wr_hit)
        begin
            store_reg[wr_plane[PIDX_W-1:0]][wr_coef] <= wr_data;
        end
    end

    assign rd_data = store_reg[rd_plane][rd_coef];

endmodule

/* src/fct_dot_unit.sv */
// Shared multiply-accumulate unit: one term of a plane distance per cycle.
module fct_dot_unit import fct_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  dot_op_t                      op,
    input  logic signed [COEF_BITS-1:0]  coef,
    input  logic signed [COORD_BITS-1:0] coord,
    input  logic [COORD_BITS-2:0]        radius,
    output dot_res_t                     res
);

    localparam int PROD_W  = COEF_BITS + COORD_BITS;
    localparam int SUM_W   = ((COEF_BITS > COORD_BITS) ? COEF_BITS : COORD_BITS) + 1;
    localparam int CONST_W = SUM_W + FRAC_BITS;
    localparam int ACC_W   = ((PROD_W > CONST_W) ? PROD_W : CONST_W) + 3;

    logic signed [PROD_W-1:0] mul_full;
    logic signed [SUM_W-1:0]  const_sum;
    logic signed [ACC_W-1:0]  const_term;
    logic signed [ACC_W-1:0]  term;
    logic signed [ACC_W-1:0]  sum;

    dot_op_t                  op_reg;
    logic signed [ACC_W-1:0]  term_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    dot_res_t                 res_reg;

    // Form this step's term: a product, or the aligned offset d + radius
    assign mul_full   = PROD_W'(coef) * PROD_W'(coord);
    assign const_sum  = SUM_W'(coef) + SUM_W'($signed({1'b0, radius}));
    assign const_term = ACC_W'(const_sum) <<< FRAC_BITS;
    assign term       = op.use_const ? const_term : ACC_W'(mul_full);

    // Accumulate the registered term
    assign sum = op_reg.first ? term_reg : (acc_reg + term_reg);

    // Register the step's control fields
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg <= '0;
        end
        else
        begin
            op_reg <= op;
        end
    end

    always_ff @(posedge clk)
    begin
        if (op.valid)
        begin
            term_reg <= term;
        end
        if (op_reg.valid)
        begin
            acc_reg <= sum;
        end
    end

    // Report the sign of each finished distance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_reg <= '0;
        end
        else
        begin
            res_reg.valid     <= op_reg.valid && op_reg.last;
            res_reg.neg       <= sum[ACC_W-1];
            res_reg.plane_end <= op_reg.plane_end;
            res_reg.query_end <= op_reg.query_end;
        end
    end

    assign res = res_reg;

endmodule

/* tb/frustum_cull_tester_checker.sv */
// Checker for the frustum cull tester: plane store predictor and result scoreboard.
`timescale 1ns / 1ps

module frustum_cull_tester_checker
    import fct_pkg::*;
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    input  logic                             in_ready,
    input  logic [1:0]                       kind,
    input  logic [2:0]                       plane_index,
    input  logic [1:0]                       coef_index,
    input  logic signed [COEF_BITS-1:0]      coef_value,
    input  logic signed [COORD_BITS_DEF-1:0] point_x,
    input  logic signed [COORD_BITS_DEF-1:0] point_y,
    input  logic signed [COORD_BITS_DEF-1:0] point_z,
    input  logic [COORD_BITS_DEF-2:0]        radius,
    input  logic signed [COORD_BITS_DEF-1:0] max_x,
    input  logic signed [COORD_BITS_DEF-1:0] max_y,
    input  logic signed [COORD_BITS_DEF-1:0] max_z,
    input  logic                             out_valid,
    input  logic                             out_ready,
    input  logic                             visible,
    input  logic                             fully_inside,
    output int                               mismatch_count,
    output int                               pending_count,
    output int                               plane_writes,
    output int                               sphere_tests,
    output int                               box_tests,
    output int                               visible_hits,
    output int                               inside_hits
);

    localparam int CW          = COORD_BITS_DEF;
    localparam int STORE_WORDS = NUM_PLANES_DEF * NUM_COEFS;
    localparam int REPORT_MAX  = 10;

    typedef struct packed {
        logic [1:0] kind;
        logic       visible;
        logic       fully_inside;
    } cull_verdict_t;

    logic signed [COEF_BITS-1:0] coef_store [STORE_WORDS];
    cull_verdict_t               verdict_queue [$];

    // Exact plane distance scaled by 2^(2*FRAC), with extra added at the d position
    function automatic logic signed [127:0] plane_distance(
        input int                     p,
        input logic signed [CW-1:0]   x,
        input logic signed [CW-1:0]   y,
        input logic signed [CW-1:0]   z,
        input logic [CW-2:0]          extra
    );
        logic signed [127:0] a, b, c, d, px, py, pz, ex;
        a  = coef_store[p * NUM_COEFS + COEF_A];
        b  = coef_store[p * NUM_COEFS + COEF_B];
        c  = coef_store[p * NUM_COEFS + COEF_C];
        d  = coef_store[p * NUM_COEFS + COEF_D];
        px = x;
        py = y;
        pz = z;
        ex = extra;
        return a * px + b * py + c * pz + (d <<< FRAC_BITS_DEF) + (ex <<< FRAC_BITS_DEF);
    endfunction

    // Sphere: culled by any plane whose distance plus radius is negative
    function automatic cull_verdict_t predict_sphere(
        input logic signed [CW-1:0] x,
        input logic signed [CW-1:0] y,
        input logic signed [CW-1:0] z,
        input logic [CW-2:0]        r
    );
        cull_verdict_t v;
        v.kind         = KIND_SPHERE;
        v.visible      = 1'b1;
        v.fully_inside = 1'b0;
        for (int p = 0; p < NUM_PLANES_DEF; p++)
            if (plane_distance(p, x, y, z, r) < 0)
                v.visible = 1'b0;
        return v;
    endfunction

    // Box: culled when all corners fall behind one plane; corners taken as given
    function automatic cull_verdict_t predict_box(
        input logic signed [CW-1:0] lx,
        input logic signed [CW-1:0] ly,
        input logic signed [CW-1:0] lz,
        input logic signed [CW-1:0] hx,
        input logic signed [CW-1:0] hy,
        input logic signed [CW-1:0] hz
    );
        cull_verdict_t         v;
        int                    behind;
        logic signed [CW-1:0]  cx, cy, cz;
        v.kind         = KIND_BOX;
        v.visible      = 1'b1;
        v.fully_inside = 1'b1;
        for (int p = 0; p < NUM_PLANES_DEF; p++) begin
            behind = 0;
            for (int k = 0; k < NUM_CORNERS; k++) begin
                cx = ((k & 1) != 0) ? hx : lx;
                cy = ((k & 2) != 0) ? hy : ly;
                cz = ((k & 4) != 0) ? hz : lz;
                if (plane_distance(p, cx, cy, cz, '0) < 0)
                    behind++;
            end
            if (behind != 0)
                v.fully_inside = 1'b0;
            if (behind == NUM_CORNERS) begin
                v.visible      = 1'b0;
                v.fully_inside = 1'b0;
                return v;
            end
        end
        return v;
    endfunction

    // Track input beats, predict, and score output beats
    always @(posedge clk or negedge rst_n) begin : watch
        cull_verdict_t want;
        if (!rst_n) begin
            foreach (coef_store[i])
                coef_store[i] = '0;
            verdict_queue.delete();
            mismatch_count = 0;
            pending_count  = 0;
            plane_writes   = 0;
            sphere_tests   = 0;
            box_tests      = 0;
            visible_hits   = 0;
            inside_hits    = 0;
        end
        else begin
            if (in_valid && in_ready) begin
                case (kind)
                    KIND_WRITE: begin
                        // drop writes beyond the last plane
                        if (plane_index < NUM_PLANES_DEF) begin
                            coef_store[plane_index * NUM_COEFS + coef_index] = coef_value;
                            plane_writes++;
                        end
                    end
                    KIND_SPHERE: begin
                        verdict_queue.push_back(predict_sphere(point_x, point_y, point_z,
                                                               radius));
                        sphere_tests++;
                    end
                    KIND_BOX: begin
                        verdict_queue.push_back(predict_box(point_x, point_y, point_z,
                                                            max_x, max_y, max_z));
                        box_tests++;
                    end
                    default: ;
                endcase
            end

            if (out_valid && out_ready) begin
                if (verdict_queue.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= REPORT_MAX)
                        $display("[%0t] unexpected result beat visible=%b fully_inside=%b",
                                 $realtime, visible, fully_inside);
                end
                else begin
                    want = verdict_queue.pop_front();
                    if (visible !== want.visible || fully_inside !== want.fully_inside) begin
                        mismatch_count++;
                        if (mismatch_count <= REPORT_MAX)
                            $display("[%0t] %s test: expected visible=%b fully_inside=%b, %s%b %s%b",
                                     $realtime, (want.kind == KIND_BOX) ? "box" : "sphere",
                                     want.visible, want.fully_inside,
                                     "got visible=", visible, "fully_inside=", fully_inside);
                    end
                    if (want.visible)
                        visible_hits++;
                    if (want.fully_inside)
                        inside_hits++;
                end
            end
            pending_count = verdict_queue.size();
        end
    end

endmodule

/* tb/frustum_cull_tester_tb.sv */
// Testbench top for the frustum cull tester: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module frustum_cull_tester_tb;
    import fct_pkg::*;

    localparam int         CW              = COORD_BITS_DEF;
    localparam int         RESET_CYCLES    = 12;
    localparam int         CYCLE_LIMIT     = 1_500_000;
    localparam int         DRAIN_CYCLES    = 250;
    localparam int         HOLD_CYCLES     = 400;
    localparam int         ITEMS_PER_PHASE = 300;
    localparam logic [1:0] KIND_SPARE      = 2'd3;

    typedef struct packed {
        logic [1:0]    kind;
        logic [2:0]    plane;
        logic [1:0]    coef;
        logic [31:0]   value;
        logic [CW-1:0] lo_x;
        logic [CW-1:0] lo_y;
        logic [CW-1:0] lo_z;
        logic [CW-2:0] rad;
        logic [CW-1:0] hi_x;
        logic [CW-1:0] hi_y;
        logic [CW-1:0] hi_z;
    } cull_item_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    logic [1:0]                  kind;
    logic [2:0]                  plane_index;
    logic [1:0]                  coef_index;
    logic signed [COEF_BITS-1:0] coef_value;
    logic signed [CW-1:0]        point_x;
    logic signed [CW-1:0]        point_y;
    logic signed [CW-1:0]        point_z;
    logic [CW-2:0]               radius;
    logic signed [CW-1:0]        max_x;
    logic signed [CW-1:0]        max_y;
    logic signed [CW-1:0]        max_z;
    logic                        out_valid;
    logic                        out_ready;
    logic                        visible;
    logic                        fully_inside;

    int mismatch_count;
    int pending_count;
    int plane_writes;
    int sphere_tests;
    int box_tests;
    int visible_hits;
    int inside_hits;

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned counted_items;
    int unsigned dropped_items;
    int unsigned hold_left;
    int unsigned cycle_count;
    bit          hold_armed;
    bit          hold_done;

    frustum_cull_tester u_top (.*);

    frustum_cull_tester_checker u_checker (.*);

    // Clock
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // Any word: full random, extremes, mid-size or tiny values
    function automatic logic [31:0] draw_word();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: begin
                case ($urandom_range(0, 4))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    3:       return 32'hFFFF_FFFF;
                    default: return 32'h0000_0001;
                endcase
            end
            2:       return $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
            default: return $urandom_range(0, 128) - 64;
        endcase
    endfunction

    // Frustum-like coefficient: normals within +-2.0, d mostly positive
    function automatic logic [31:0] draw_coef(input logic [1:0] which);
        if ($urandom_range(0, 9) == 0)
            return draw_word();
        if (which == COEF_D)
            return $urandom_range(0, 32'h0040_0000) - 32'h0004_0000;
        return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
    endfunction

    // Coordinate near the origin (+-16.0), sometimes anything
    function automatic logic [CW-1:0] draw_coord();
        if ($urandom_range(0, 4) == 0)
            return draw_word();
        return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endfunction

    // Fully random beat; unused fields keep their random bits
    function automatic cull_item_t random_item();
        cull_item_t it;
        it.kind  = 2'($urandom_range(0, 3));
        it.plane = 3'($urandom_range(0, 7));
        it.coef  = 2'($urandom_range(0, 3));
        it.value = $urandom();
        it.lo_x  = $urandom();
        it.lo_y  = $urandom();
        it.lo_z  = $urandom();
        it.rad   = 31'($urandom());
        it.hi_x  = $urandom();
        it.hi_y  = $urandom();
        it.hi_z  = $urandom();
        return it;
    endfunction

    // Offer one beat after a random gap and hold it until accepted
    task automatic send_beat(input cull_item_t it);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        kind        <= it.kind;
        plane_index <= it.plane;
        coef_index  <= it.coef;
        coef_value  <= it.value;
        point_x     <= it.lo_x;
        point_y     <= it.lo_y;
        point_z     <= it.lo_z;
        radius      <= it.rad;
        max_x       <= it.hi_x;
        max_y       <= it.hi_y;
        max_z       <= it.hi_z;
        do
            @(posedge clk);
        while (!in_ready);
        if (it.kind == KIND_SPARE || (it.kind == KIND_WRITE && it.plane >= NUM_PLANES_DEF))
            dropped_items++;
        else
            counted_items++;
    endtask

    task automatic write_coef(input logic [2:0] p, input logic [1:0] c, input logic [31:0] v);
        cull_item_t it;
        it       = random_item();
        it.kind  = KIND_WRITE;
        it.plane = p;
        it.coef  = c;
        it.value = v;
        send_beat(it);
    endtask

    task automatic sphere_test(input logic [CW-1:0] x, input logic [CW-1:0] y,
                               input logic [CW-1:0] z, input logic [CW-2:0] r);
        cull_item_t it;
        it      = random_item();
        it.kind = KIND_SPHERE;
        it.lo_x = x;
        it.lo_y = y;
        it.lo_z = z;
        it.rad  = r;
        send_beat(it);
    endtask

    task automatic box_test(input logic [CW-1:0] lx, input logic [CW-1:0] ly,
                            input logic [CW-1:0] lz, input logic [CW-1:0] hx,
                            input logic [CW-1:0] hy, input logic [CW-1:0] hz);
        cull_item_t it;
        it      = random_item();
        it.kind = KIND_BOX;
        it.lo_x = lx;
        it.lo_y = ly;
        it.lo_z = lz;
        it.hi_x = hx;
        it.hi_y = hy;
        it.hi_z = hz;
        send_beat(it);
    endtask

    task automatic run_directed();
        cull_item_t it;
        // cleared store: every query passes, boxes fully inside
        sphere_test(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        box_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        // spare kind and planes past the end are dropped
        it      = random_item();
        it.kind = KIND_SPARE;
        send_beat(it);
        write_coef(3'd6, COEF_A, 32'h8000_0000);
        write_coef(3'd7, COEF_D, 32'h7FFF_FFFF);
        // plane 0 becomes x >= 0
        write_coef(3'd0, COEF_A, 32'h0001_0000);
        // point on the plane passes, just behind fails, radius lifts it back
        sphere_test(32'h0000_0000, $urandom(), $urandom(), 31'd0);
        sphere_test(32'hFFFF_FFFF, $urandom(), $urandom(), 31'd0);
        sphere_test(32'hFFFF_FFFF, $urandom(), $urandom(), 31'd1);
        // inverted box straddling, box fully behind, box touching the plane
        box_test(32'h0000_0001, $urandom(), $urandom(), 32'hFFFF_FFFD, $urandom(), $urandom());
        box_test(32'hFFFF_FFFB, $urandom(), $urandom(), 32'hFFFF_FFFF, $urandom(), $urandom());
        box_test(32'h0000_0000, $urandom(), $urandom(), 32'h0000_0005, $urandom(), $urandom());
        // extreme coefficients on the last plane
        write_coef(3'd5, COEF_A, 32'h8000_0000);
        write_coef(3'd5, COEF_B, 32'h7FFF_FFFF);
        write_coef(3'd5, COEF_C, 32'h8000_0000);
        write_coef(3'd5, COEF_D, 32'h7FFF_FFFF);
        sphere_test(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
        sphere_test(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 31'd0);
        box_test(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    endtask

    // Mostly plane updates followed by queries, the rest random noise
    task automatic run_random(input int unsigned count);
        int unsigned      stop_at;
        int unsigned      n;
        logic [CW-1:0]    cx, cy, cz, hx, hy, hz, t;
        stop_at = counted_items + count;
        while (counted_items < stop_at) begin
            if ($urandom_range(0, 99) < 70) begin
                if ($urandom_range(0, 3) == 0) begin
                    for (int p = 0; p < NUM_PLANES_DEF; p++)
                        for (int c = 0; c < NUM_COEFS; c++)
                            write_coef(3'(p), 2'(c), draw_coef(2'(c)));
                end
                else begin
                    n = $urandom_range(1, 6);
                    repeat (n) begin
                        t = $urandom_range(0, 3);
                        write_coef(3'($urandom_range(0, NUM_PLANES_DEF - 1)), t[1:0],
                                   draw_coef(t[1:0]));
                    end
                end
                n = $urandom_range(1, 6);
                repeat (n) begin
                    cx = draw_coord();
                    cy = draw_coord();
                    cz = draw_coord();
                    if ($urandom_range(0, 1) == 0) begin
                        sphere_test(cx, cy, cz, ($urandom_range(0, 9) < 7)
                                    ? 31'($urandom_range(0, 32'h0004_0000)) : 31'($urandom()));
                    end
                    else begin
                        hx = $urandom_range(0, 32'h0008_0000);
                        hy = $urandom_range(0, 32'h0008_0000);
                        hz = $urandom_range(0, 32'h0008_0000);
                        // occasionally pass min and max swapped
                        if ($urandom_range(0, 6) == 0)
                            box_test(cx + hx, cy + hy, cz + hz, cx - hx, cy - hy, cz - hz);
                        else
                            box_test(cx - hx, cy - hy, cz - hz, cx + hx, cy + hy, cz + hz);
                    end
                end
            end
            else begin
                send_beat(random_item());
            end
        end
    endtask

    // Receiver: random stalls plus one long hold-off to back up the block
    always @(posedge clk) begin
        if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else begin
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Watchdog
    initial begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still outstanding",
                 cycle_count, pending_count);
        $display("Mismatches found");
        $finish;
    end

    // Stimulus and verdict
    initial begin : stimulus
        rst_n         <= 1'b0;
        in_valid      <= 1'b0;
        kind          <= '0;
        plane_index   <= '0;
        coef_index    <= '0;
        coef_value    <= '0;
        point_x       <= '0;
        point_y       <= '0;
        point_z       <= '0;
        radius        <= '0;
        max_x         <= '0;
        max_y         <= '0;
        max_z         <= '0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        counted_items = 0;
        dropped_items = 0;
        hold_armed    = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();

        send_idle_pct = 16;
        recv_idle_pct = 61;
        run_random(ITEMS_PER_PHASE);

        send_idle_pct = 61;
        recv_idle_pct = 16;
        hold_armed    = 1'b1;
        run_random(ITEMS_PER_PHASE);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(ITEMS_PER_PHASE);

        // drain: wait for outstanding results, then allow a full box latency
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d plane writes, %0d sphere tests, %0d box tests, %0d dropped beats",
                 plane_writes, sphere_tests, box_tests, dropped_items);
        $display("Outcomes: %0d visible, %0d fully inside, %0d culled, in %0d cycles",
                 visible_hits, inside_hits, sphere_tests + box_tests - visible_hits,
                 cycle_count);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
